/* sv/hpas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hpas_pkg;

  // Grid limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int HALF_COLS = MAX_WIDTH / 2 + 1;
  localparam int HALF_AW   = $clog2(HALF_COLS);

  // Field and register widths
  localparam int VALUE_W    = 16;
  localparam int SIZE_W     = 11;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int GRID_SIZE_RESET = 1024;
  localparam int THRESH_RESET    = 1;

  // Averaging datapath: five Q8.8 terms, reciprocal multiply
  localparam int SUM_W       = VALUE_W + 3;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Exact for sums below 2^19 with a shift of 21
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(699051);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(524288);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(419431);

  // Result queue, power of two depth
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_BY_3,
    DIV_BY_4,
    DIV_BY_5
  } div_sel_t;

  // One averaging job; absent neighbors are zero terms
  typedef struct packed {
    logic                        valid;
    logic [4:0][VALUE_W-1:0]     term;
    div_sel_t                    div;
    logic                        last;
    logic                        flag;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    div_sel_t         div;
    logic             last;
    logic             flag;
  } sum_t;

  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] prod;
    logic              last;
    logic              flag;
  } prod_t;

  typedef struct packed {
    logic [VALUE_W-1:0] new_value;
    logic               last_of_frame;
    logic               needs_another_pass;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_slot_t;

  function automatic div_sel_t div_for_count(logic [2:0] terms);
    div_sel_t sel;
    case (terms)
      3'd3:    sel = DIV_BY_3;
      3'd4:    sel = DIV_BY_4;
      default: sel = DIV_BY_5;
    endcase
    return sel;
  endfunction

  function automatic logic [RECIP_W-1:0] recip(div_sel_t sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_BY_3: r = RECIP_3;
      DIV_BY_4: r = RECIP_4;
      DIV_BY_5: r = RECIP_5;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/hpas_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Grid cell / flush beats
interface hpas_cell_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [hpas_pkg::VALUE_W-1:0]  cell_value;

  modport source (output valid, req_type, cell_value, input ready);
  modport sink   (input valid, req_type, cell_value, output ready);
endinterface

// Averaged result beats
interface hpas_result_if;
  logic                          valid;
  logic                          ready;
  logic [hpas_pkg::VALUE_W-1:0]  new_value;
  logic                          last_of_frame;
  logic                          needs_another_pass;

  modport source (output valid, new_value, last_of_frame, needs_another_pass, input ready);
  modport sink   (input valid, new_value, last_of_frame, needs_another_pass, output ready);
endinterface

// Register writes
interface hpas_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hpas_pkg::CFG_IDX_W-1:0]   index;
  logic [hpas_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/hpas_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual port RAM, registered read, write-first on a same-address hit
module hpas_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/hpas_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame position, line store, stencil window and top/bottom row compare.
// Line store entry c holds {row r-1, row r-2} at column c. Entry c+2 is
// prefetched on each cell beat so the right neighbor is on hand.
module hpas_window (
  input  logic                    clk,
  input  logic                    rst,
  hpas_cell_if.sink               cells,
  hpas_cfg_if.sink                cfg,
  input  logic                    room,
  output hpas_pkg::lane_t [1:0]   lanes,
  output logic [1:0]              claim
);

  import hpas_pkg::*;

  function automatic logic [WIDTH_W-1:0] clamp_width(logic [SIZE_W-1:0] raw);
    logic [WIDTH_W-1:0] res;
    if (raw < SIZE_W'(2)) res = WIDTH_W'(2);
    else if (32'(raw) > MAX_WIDTH) res = WIDTH_W'(MAX_WIDTH);
    else res = WIDTH_W'(raw);
    return res;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(logic [SIZE_W-1:0] raw);
    logic [HEIGHT_W-1:0] res;
    if (raw < SIZE_W'(2)) res = HEIGHT_W'(2);
    else if (32'(raw) > MAX_HEIGHT) res = HEIGHT_W'(MAX_HEIGHT);
    else res = HEIGHT_W'(raw);
    return res;
  endfunction

  logic [WIDTH_W-1:0]   grid_w;
  logic [HEIGHT_W-1:0]  grid_h;
  logic [THRESH_W-1:0]  thresh;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic                 drain;
  logic                 diff_seen;

  logic [2*VALUE_W-1:0] ahead;
  logic [2*VALUE_W-1:0] rd_line;
  logic [VALUE_W-1:0]   left_up;
  logic [VALUE_W-1:0]   prev_cell;
  logic [VALUE_W-1:0]   prev2_cell;
  logic                 chk_valid;
  logic [VALUE_W-1:0]   chk_value;
  logic [VALUE_W-1:0]   top_rd;

  logic                 accept;
  logic                 cell_beat;
  logic                 flush_beat;
  logic                 first_col, last_col, first_row, last_row;
  logic                 row_gt1, col_gt1, half_col;
  logic [WIDTH_W:0]     col_plus2;
  logic [COL_W-1:0]     rd_addr;
  logic [VALUE_W-1:0]   a_up1, a_up2, b_up1;
  logic                 diff_hit;
  logic [2:0]           cnt0, cnt1;
  lane_t [1:0]          lanes_next;

  assign cells.ready = room;
  assign cfg.ready   = 1'b1;

  assign accept     = cells.valid && cells.ready;
  assign cell_beat  = accept && !cells.req_type && !drain;
  assign flush_beat = accept && cells.req_type && drain;

  // Position decode
  assign first_col = (col == '0);
  assign last_col  = (WIDTH_W'(col) == grid_w - WIDTH_W'(1));
  assign first_row = (row == '0);
  assign last_row  = (HEIGHT_W'(row) == grid_h - HEIGHT_W'(1));
  assign row_gt1   = (row > ROW_W'(1));
  assign col_gt1   = (col > COL_W'(1));
  assign half_col  = (WIDTH_W'(col) <= (grid_w >> 1));

  // Prefetch address: column + 2, wrapped into the row
  assign col_plus2 = (WIDTH_W + 1)'(col) + (WIDTH_W + 1)'(2);
  assign rd_addr   = (col_plus2 >= (WIDTH_W + 1)'(grid_w)) ?
                     COL_W'(col_plus2 - (WIDTH_W + 1)'(grid_w)) : COL_W'(col_plus2);

  assign a_up1 = ahead[2*VALUE_W-1:VALUE_W];
  assign a_up2 = ahead[VALUE_W-1:0];
  assign b_up1 = rd_line[2*VALUE_W-1:VALUE_W];

  hpas_ram #(.DEPTH(MAX_WIDTH), .WIDTH(2*VALUE_W)) u_line_ram (
    .clk   (clk),
    .we    (cell_beat),
    .waddr (col),
    .wdata ({cells.cell_value, a_up1}),
    .re    (cell_beat),
    .raddr (rd_addr),
    .rdata (rd_line)
  );

  hpas_ram #(.DEPTH(HALF_COLS), .WIDTH(VALUE_W)) u_top_ram (
    .clk   (clk),
    .we    (cell_beat && first_row && half_col),
    .waddr (HALF_AW'(col)),
    .wdata (cells.cell_value),
    .re    (cell_beat && last_row && half_col),
    .raddr (HALF_AW'(col)),
    .rdata (top_rd)
  );

  // Top row minus bottom row against threshold, in the cycle after the read
  assign diff_hit = chk_valid && (top_rd > chk_value) &&
                    ((top_rd - chk_value) > thresh);

  // Lane jobs for this beat
  always_comb begin
    lanes_next = '0;
    cnt0 = 3'd2 + 3'(row_gt1) + 3'(!first_col) + 3'(!last_col);
    cnt1 = 3'd3 + 3'(col_gt1);
    if (cell_beat && !first_row) begin
      lanes_next[0].valid   = 1'b1;
      lanes_next[0].term[0] = a_up1;
      lanes_next[0].term[1] = row_gt1 ? a_up2 : '0;
      lanes_next[0].term[2] = cells.cell_value;
      lanes_next[0].term[3] = first_col ? '0 : left_up;
      lanes_next[0].term[4] = last_col ? '0 : b_up1;
      lanes_next[0].div     = div_for_count(cnt0);
    end
    if (cell_beat && last_row && !first_col) begin
      lanes_next[1].valid   = 1'b1;
      lanes_next[1].term[0] = prev_cell;
      lanes_next[1].term[1] = left_up;
      lanes_next[1].term[2] = col_gt1 ? prev2_cell : '0;
      lanes_next[1].term[3] = cells.cell_value;
      lanes_next[1].div     = div_for_count(cnt1);
    end
    if (flush_beat) begin
      lanes_next[0].valid   = 1'b1;
      lanes_next[0].term[0] = prev_cell;
      lanes_next[0].term[1] = left_up;
      lanes_next[0].term[2] = prev2_cell;
      lanes_next[0].div     = DIV_BY_3;
      lanes_next[0].last    = 1'b1;
      lanes_next[0].flag    = diff_seen || diff_hit;
    end
  end

  assign claim = 2'(lanes_next[0].valid) + 2'(lanes_next[1].valid);

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w    <= clamp_width(SIZE_W'(GRID_SIZE_RESET));
      grid_h    <= clamp_height(SIZE_W'(GRID_SIZE_RESET));
      thresh    <= THRESH_W'(THRESH_RESET);
      col       <= '0;
      row       <= '0;
      drain     <= 1'b0;
      diff_seen <= 1'b0;
      chk_valid <= 1'b0;
      lanes     <= '0;
    end else begin
      lanes     <= lanes_next;
      chk_valid <= cell_beat && last_row && half_col;
      if (diff_hit) begin
        diff_seen <= 1'b1;
      end
      if (cell_beat) begin
        if (last_col) begin
          col <= '0;
          if (last_row) begin
            row   <= '0;
            drain <= 1'b1;
          end else begin
            row <= row + ROW_W'(1);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
      if (flush_beat) begin
        col       <= '0;
        row       <= '0;
        drain     <= 1'b0;
        diff_seen <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          CFG_GRID_WIDTH: begin
            grid_w    <= clamp_width(cfg.data[SIZE_W-1:0]);
            col       <= '0;
            row       <= '0;
            drain     <= 1'b0;
            diff_seen <= 1'b0;
          end
          CFG_GRID_HEIGHT: begin
            grid_h    <= clamp_height(cfg.data[SIZE_W-1:0]);
            col       <= '0;
            row       <= '0;
            drain     <= 1'b0;
            diff_seen <= 1'b0;
          end
          CFG_THRESHOLD: begin
            thresh <= cfg.data[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (cell_beat) begin
      ahead      <= rd_line;
      left_up    <= a_up1;
      prev2_cell <= prev_cell;
      prev_cell  <= cells.cell_value;
      chk_value  <= cells.cell_value;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WIDTH_W'(col) < grid_w)
    else $error("column position past grid width");

  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    HEIGHT_W'(row) < grid_h)
    else $error("row position past grid height");

endmodule

`default_nettype wire

/* sv/hpas_divide.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-lane average: sum stage, reciprocal multiply stage, then shift
module hpas_divide (
  input  logic                         clk,
  input  logic                         rst,
  input  hpas_pkg::lane_t [1:0]        lanes,
  output hpas_pkg::result_slot_t [1:0] slots
);

  import hpas_pkg::*;

  function automatic logic [SUM_W-1:0] lane_sum(lane_t ln);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ln.term[0]) + SUM_W'(ln.term[1]) + SUM_W'(ln.term[2]) +
        SUM_W'(ln.term[3]) + SUM_W'(ln.term[4]);
    return s;
  endfunction

  sum_t  [1:0] sum_q;
  prod_t [1:0] prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_q  <= '0;
      prod_q <= '0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        sum_q[k].valid  <= lanes[k].valid;
        sum_q[k].sum    <= lane_sum(lanes[k]);
        sum_q[k].div    <= lanes[k].div;
        sum_q[k].last   <= lanes[k].last;
        sum_q[k].flag   <= lanes[k].flag;
        prod_q[k].valid <= sum_q[k].valid;
        prod_q[k].prod  <= PROD_W'(sum_q[k].sum) * PROD_W'(recip(sum_q[k].div));
        prod_q[k].last  <= sum_q[k].last;
        prod_q[k].flag  <= sum_q[k].flag;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      slots[k].valid                   = prod_q[k].valid;
      slots[k].data.new_value          = prod_q[k].prod[RECIP_SHIFT +: VALUE_W];
      slots[k].data.last_of_frame      = prod_q[k].last;
      slots[k].data.needs_another_pass = prod_q[k].flag;
    end
  end

  a_lane_order: assert property (@(posedge clk) disable iff (rst)
    lanes[1].valid |=> sum_q[0].valid && sum_q[1].valid)
    else $error("second lane job without first lane job");

endmodule

`default_nettype wire

/* sv/hpas_outq.sv */
`timescale 1ns / 1ps
`default_nettype none

// Result queue with credit count; accepts two pushes per cycle
module hpas_outq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   claim,
  input  hpas_pkg::result_slot_t [1:0] slots,
  hpas_result_if.source                results,
  output logic                         room
);

  import hpas_pkg::*;

  result_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    head, tail;
  logic [CREDIT_W-1:0]  count, reserved;
  logic                 pop, push0, push1;
  result_t              head_data;

  assign push0     = slots[0].valid;
  assign push1     = slots[1].valid;
  assign pop       = results.valid && results.ready;
  assign head_data = queue[head];

  assign results.valid              = (count != '0);
  assign results.new_value          = head_data.new_value;
  assign results.last_of_frame      = head_data.last_of_frame;
  assign results.needs_another_pass = head_data.needs_another_pass;

  // Room for the two results a cell beat can produce
  assign room = (reserved <= CREDIT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      reserved <= '0;
    end else begin
      head     <= head + QPTR_W'(pop);
      tail     <= tail + QPTR_W'(push0) + QPTR_W'(push1);
      count    <= count + CREDIT_W'(push0) + CREDIT_W'(push1) - CREDIT_W'(pop);
      reserved <= reserved + CREDIT_W'(claim) - CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      queue[tail] <= slots[0].data;
    end
    if (push1) begin
      queue[tail + QPTR_W'(push0)] <= slots[1].data;
    end
  end

  a_count_covered: assert property (@(posedge clk) disable iff (rst)
    count <= reserved)
    else $error("queued results exceed reserved credits");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= CREDIT_W'(QUEUE_DEPTH))
    else $error("credit count beyond queue depth");

endmodule

`default_nettype wire

/* sv/heat_plane_averaging_stencil.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                        Accept
// cells     in   req_type, cell_value[15:0]                      valid & ready
// results   out  new_value[15:0], last_of_frame,                 valid & ready
//                needs_another_pass
// cfg       in   index[1:0], data[15:0]                          valid & ready
//
// One cell beat per cycle while the result queue has room. The first row
// gives no results and the rows between give one each; in the last row a
// beat past the first column gives two, so the one-result-per-cycle output
// port sets the pace there. Results pass the lane, sum and product registers
// and the result queue. Reset is synchronous; no clearing pass, line store
// reads are prefetched. Output stalls fill an 8-entry result queue; cells is
// held off when fewer than two entries remain unclaimed.
module heat_plane_averaging_stencil (
  input  logic           clk,
  input  logic           rst,
  hpas_cell_if.sink      cells,
  hpas_result_if.source  results,
  hpas_cfg_if.sink       cfg
);

  import hpas_pkg::*;

  lane_t        [1:0] lanes;
  result_slot_t [1:0] slots;
  logic         [1:0] claim;
  logic               room;

  hpas_window u_window (
    .clk   (clk),
    .rst   (rst),
    .cells (cells),
    .cfg   (cfg),
    .room  (room),
    .lanes (lanes),
    .claim (claim)
  );

  hpas_divide u_divide (
    .clk   (clk),
    .rst   (rst),
    .lanes (lanes),
    .slots (slots)
  );

  hpas_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .claim   (claim),
    .slots   (slots),
    .results (results),
    .room    (room)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hpas_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_CYCLES  = 400;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_BEATS  = 800;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic {BEAT_CELL = 1'b0, BEAT_FLUSH = 1'b1} beat_kind_t;
  typedef enum logic [1:0] {ROW_CELL, ROW_FLUSH, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_SMOOTH, FILL_EXTREME} fill_t;
  typedef enum logic [1:0] {FRAME_NOISE, FRAME_ABANDON, FRAME_FULL} frame_t;

  // n_typed < 0: expectation comes from the stencil model below
  typedef struct {
    row_kind_t          kind;
    cfg_reg_t           sel;
    logic [VALUE_W-1:0] arg;
    int                 n_typed;
    result_t            first;
    result_t            second;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic clk;
  logic rst;

  hpas_cell_if   cells_if ();
  hpas_result_if res_if ();
  hpas_cfg_if    cfg_if ();

  heat_plane_averaging_stencil u_top (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  int fail_count = 0;
  int cycle_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_pending = 1'b0;

  // Stencil model state
  logic [VALUE_W-1:0]  plane [3][MAX_WIDTH];
  logic [VALUE_W-1:0]  top_row [HALF_COLS];
  int                  cur_row;
  int                  cur_col;
  bit                  frame_done;
  bit                  gap_seen;
  logic [SIZE_W-1:0]   cols_reg;
  logic [SIZE_W-1:0]   rows_reg;
  logic [THRESH_W-1:0] thresh_reg;
  result_t             awaited [$];

  // 2x2 grid (width 0 saturates up, height 1 likewise), then 2x3
  stim_row_t directed_rows [25] = '{
    '{ROW_CFG,   CFG_GRID_WIDTH,  16'hF800, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CFG,   CFG_GRID_HEIGHT, 16'h0001, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CFG,   CFG_THRESHOLD,   16'h0000, 0,  NO_RESULT, NO_RESULT},
    '{ROW_FLUSH, CFG_GRID_WIDTH,  16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, 1,  '{16'hAAAA, 1'b0, 1'b0}, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, 2,  '{16'hAAAA, 1'b0, 1'b0},
                                                '{16'h5555, 1'b0, 1'b0}},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h1234, 0,  NO_RESULT, NO_RESULT},
    '{ROW_FLUSH, CFG_GRID_WIDTH,  16'h0000, 1,  '{16'h5555, 1'b1, 1'b1}, NO_RESULT},
    '{ROW_FLUSH, CFG_GRID_WIDTH,  16'h0000, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CFG,   CFG_THRESHOLD,   16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, -1, NO_RESULT, NO_RESULT},
    '{ROW_FLUSH, CFG_GRID_WIDTH,  16'h8001, 1,  '{16'h5555, 1'b1, 1'b0}, NO_RESULT},
    '{ROW_CFG,   CFG_GRID_HEIGHT, 16'h0003, 0,  NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h8000, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0001, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'hFFFF, -1, NO_RESULT, NO_RESULT},
    '{ROW_CELL,  CFG_GRID_WIDTH,  16'h0000, -1, NO_RESULT, NO_RESULT},
    '{ROW_FLUSH, CFG_GRID_WIDTH,  16'h7FFF, -1, NO_RESULT, NO_RESULT}
  };

  function automatic int cols_eff();
    if (cols_reg < 2) return 2;
    if (cols_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(cols_reg);
  endfunction

  function automatic int rows_eff();
    if (rows_reg < 2) return 2;
    if (rows_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(rows_reg);
  endfunction

  function automatic void restart_frame();
    cur_row    = 0;
    cur_col    = 0;
    frame_done = 1'b0;
    gap_seen   = 1'b0;
  endfunction

  // Mean of the cell and its in-grid neighbors, truncated
  function automatic logic [VALUE_W-1:0] averaged(int r, int c, int w, int h);
    int sum;
    int terms;
    sum   = plane[r % 3][c];
    terms = 1;
    if (r > 0) begin
      sum += plane[(r - 1) % 3][c];
      terms++;
    end
    if (r + 1 < h) begin
      sum += plane[(r + 1) % 3][c];
      terms++;
    end
    if (c > 0) begin
      sum += plane[r % 3][c - 1];
      terms++;
    end
    if (c + 1 < w) begin
      sum += plane[r % 3][c + 1];
      terms++;
    end
    return VALUE_W'(sum / terms);
  endfunction

  // Advance the grid model by one beat; returns the number of results released
  function automatic int advance_stencil(input beat_kind_t kind,
                                         input logic [VALUE_W-1:0] v,
                                         output result_t res [2]);
    int w;
    int h;
    int n;
    w      = cols_eff();
    h      = rows_eff();
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (kind == BEAT_FLUSH) begin
      if (!frame_done) return 0;
      res[0] = '{averaged(h - 1, w - 1, w, h), 1'b1, gap_seen};
      restart_frame();
      return 1;
    end
    if (frame_done || cur_row >= h || cur_col >= w) return 0;
    plane[cur_row % 3][cur_col] = v;
    // left half of the top row against the same columns of the bottom row
    if (cur_col < w / 2 + 1) begin
      if (cur_row == 0) top_row[cur_col] = v;
      if (cur_row == h - 1 && top_row[cur_col] > v && top_row[cur_col] - v > thresh_reg)
        gap_seen = 1'b1;
    end
    if (cur_row > 0) begin
      res[n] = '{averaged(cur_row - 1, cur_col, w, h), 1'b0, 1'b0};
      n++;
    end
    if (cur_row == h - 1 && cur_col > 0) begin
      res[n] = '{averaged(cur_row, cur_col - 1, w, h), 1'b0, 1'b0};
      n++;
    end
    cur_col++;
    if (cur_col == w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row == h) frame_done = 1'b1;
    return n;
  endfunction

  function automatic logic [THRESH_W-1:0] pick_threshold();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 16'h0300));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small sizes, sometimes below the minimum or a bit larger
  function automatic int pick_size_code(int hi);
    case ($urandom_range(19))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(hi + 1, hi * 3);
      default: return $urandom_range(2, hi);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] cell_sample(fill_t fill, int base);
    case (fill)
      FILL_SMOOTH:  return 16'(base + $urandom_range(0, 511));
      FILL_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:      return 16'($urandom);
    endcase
  endfunction

  // One beat on the cell channel; expectations are queued once it is taken
  task automatic send_beat(input beat_kind_t kind, input logic [VALUE_W-1:0] v,
                           input int n_typed = -1, input result_t t0 = '0,
                           input result_t t1 = '0);
    result_t res [2];
    int      n;
    while ($urandom_range(99) < send_idle_pct) begin
      cells_if.valid <= 1'b0;
      @(posedge clk);
    end
    cells_if.valid      <= 1'b1;
    cells_if.req_type   <= kind;
    cells_if.cell_value <= v;
    do @(posedge clk); while (!cells_if.ready);
    n = advance_stencil(kind, v, res);
    if (n_typed >= 0) begin
      res[0] = t0;
      res[1] = t1;
      n      = n_typed;
    end
    for (int i = 0; i < n; i++) awaited.push_back(res[i]);
  endtask

  // Stop offering cells and let every pending result come out
  task automatic drain_results();
    int waited;
    waited = 0;
    cells_if.valid <= 1'b0;
    while (awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited.size() != 0) begin
      $error("%0d expected results never arrived", awaited.size());
      fail_count++;
      awaited.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (sel)
      CFG_GRID_WIDTH: begin
        cols_reg = value[SIZE_W-1:0];
        restart_frame();
      end
      CFG_GRID_HEIGHT: begin
        rows_reg = value[SIZE_W-1:0];
        restart_frame();
      end
      CFG_THRESHOLD: thresh_reg = value[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result receiver, with one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pending) begin
        stall_pending = 1'b0;
        res_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result beat: new_value %h last_of_frame %0d",
               res_if.new_value, res_if.last_of_frame);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        if (res_if.new_value !== want.new_value) begin
          $error("new_value: expected %h, got %h", want.new_value, res_if.new_value);
          fail_count++;
        end
        if (res_if.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d",
                 want.last_of_frame, res_if.last_of_frame);
          fail_count++;
        end
        if (res_if.needs_another_pass !== want.needs_another_pass) begin
          $error("needs_another_pass: expected %0d, got %0d",
                 want.needs_another_pass, res_if.needs_another_pass);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("cycle limit reached with %0d results outstanding", awaited.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int     w_code;
    int     h_code;
    int     cols;
    int     rows_n;
    int     total;
    int     sent;
    int     mid_point;
    int     base;
    int     random_beats;
    int     frame_no;
    fill_t  fill;
    frame_t mode;

    rst                 <= 1'b1;
    cells_if.valid      <= 1'b0;
    cells_if.req_type   <= BEAT_CELL;
    cells_if.cell_value <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_GRID_WIDTH;
    cfg_if.data         <= '0;

    cols_reg   = SIZE_W'(GRID_SIZE_RESET);
    rows_reg   = SIZE_W'(GRID_SIZE_RESET);
    thresh_reg = THRESH_W'(THRESH_RESET);
    restart_frame();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 63;

    // Directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(directed_rows[i].sel, directed_rows[i].arg);
        end
        ROW_CELL: send_beat(BEAT_CELL, directed_rows[i].arg, directed_rows[i].n_typed,
                            directed_rows[i].first, directed_rows[i].second);
        default: send_beat(BEAT_FLUSH, directed_rows[i].arg, directed_rows[i].n_typed,
                           directed_rows[i].first, directed_rows[i].second);
      endcase
    end
    drain_results();

    // Both sizes saturated high: whole first row plus the start of the second
    write_reg(CFG_GRID_WIDTH, 16'h07FF);
    write_reg(CFG_GRID_HEIGHT, 16'hFFFF);
    repeat (MAX_WIDTH + 6) send_beat(BEAT_CELL, 16'($urandom));
    drain_results();

    // Tallest grid, narrow, abandoned by the next size write
    write_reg(CFG_GRID_WIDTH, 16'd2);
    write_reg(CFG_GRID_HEIGHT, 16'(MAX_HEIGHT));
    repeat (40) send_beat(BEAT_CELL, 16'($urandom));
    drain_results();

    // Random frames
    random_beats = 0;
    frame_no     = 0;
    while (random_beats < RANDOM_BEATS) begin
      case (random_beats * 3 / RANDOM_BEATS)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();

      w_code = pick_size_code(12);
      h_code = pick_size_code(8);
      case ($urandom_range(9))
        0:       mode = FRAME_NOISE;
        1:       mode = FRAME_ABANDON;
        default: mode = FRAME_FULL;
      endcase
      if (frame_no == 3) begin
        w_code = 10;
        h_code = 8;
        mode   = FRAME_FULL;
      end
      cols   = (w_code < 2) ? 2 : w_code;
      rows_n = (h_code < 2) ? 2 : h_code;
      total  = cols * rows_n;

      // upper data bits are outside the size field
      write_reg(CFG_GRID_WIDTH, {5'($urandom), 11'(w_code)});
      write_reg(CFG_GRID_HEIGHT, {5'($urandom), 11'(h_code)});
      if ($urandom_range(1) == 0) write_reg(CFG_THRESHOLD, pick_threshold());

      case ($urandom_range(2))
        0:       fill = FILL_RANDOM;
        1:       fill = FILL_SMOOTH;
        default: fill = FILL_EXTREME;
      endcase
      base = $urandom_range(0, 16'hFE00);

      if (frame_no == 3) stall_pending = 1'b1;

      case (mode)
        FRAME_NOISE: begin
          repeat ($urandom_range(5, 20))
            send_beat(beat_kind_t'($urandom_range(0, 1)), 16'($urandom));
        end
        FRAME_ABANDON: begin
          sent = $urandom_range(1, total - 1);
          repeat (sent) send_beat(BEAT_CELL, cell_sample(fill, base));
          random_beats += sent;
        end
        default: begin
          if ($urandom_range(9) == 0) send_beat(BEAT_FLUSH, 16'($urandom));
          mid_point = ($urandom_range(6) == 0) ? $urandom_range(1, total - 1) : -1;
          for (int k = 0; k < total; k++) begin
            // threshold change partway through the frame
            if (k == mid_point) begin
              drain_results();
              write_reg(CFG_THRESHOLD, pick_threshold());
            end
            send_beat(BEAT_CELL, cell_sample(fill, base));
          end
          // cell offered after the frame is complete is dropped
          if ($urandom_range(9) == 0) send_beat(BEAT_CELL, 16'($urandom));
          send_beat(BEAT_FLUSH, 16'($urandom));
          random_beats += total + 1;
        end
      endcase
      frame_no++;
    end

    drain_results();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/hpas_pkg.sv
sv/hpas_if.sv
sv/hpas_ram.sv
sv/hpas_window.sv
sv/hpas_divide.sv
sv/hpas_outq.sv
sv/heat_plane_averaging_stencil.sv
tb/sv/tb_top.sv
